/* rtl/core/etla_pkg.sv */
// shared types, constants and arithmetic helpers of the edge traction load assembler
package etla_pkg;

   typedef enum logic [1:0] {
      OP_LINEAR = 2'd0,
      OP_QUAD   = 2'd1,
      OP_POINT  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_TAN,
      ST_SQRT,
      ST_RD,
      ST_WR,
      ST_READ_RD,
      ST_READ_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_SX,
      PH_SY,
      PH_MX,
      PH_MY,
      PH_JW,
      PH_NQ,
      PH_TX,
      PH_TY
   } phase_type;

   typedef struct packed {
      logic signed [31:0] n0;
      logic signed [31:0] n1;
      logic signed [31:0] n2;
      logic signed [31:0] d0;
      logic signed [31:0] d1;
      logic signed [31:0] d2;
      logic signed [31:0] w;
   } shape_type;

   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint HALF_Q30 = 64'sd536870912;
   localparam longint S2_Q30   = 64'sd619925131;
   localparam longint S3_Q30   = 64'sd831716840;
   localparam longint W8_Q30   = 64'sd954437177;
   localparam longint W5_Q30   = 64'sd596523236;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 68;
   localparam int SUM_W  = 50;

   function automatic longint rnd_l(input longint v, input int k);
      longint m;
      longint r;
      m = (v < 0) ? -v : v;
      r = (m + (64'sd1 <<< (k - 1))) >>> k;
      return (v < 0) ? -r : r;
   endfunction

   function automatic shape_type shape_at(input bit quad, input longint s, input longint w);
      shape_type r;
      longint sq;
      sq = rnd_l(s * s, 30);
      if (quad) begin
         r.n0 = 32'(rnd_l(sq - s, 1));
         r.n1 = 32'(rnd_l(sq + s, 1));
         r.n2 = 32'(ONE_Q30 - sq);
         r.d0 = 32'(s - HALF_Q30);
         r.d1 = 32'(s + HALF_Q30);
         r.d2 = 32'(-2 * s);
      end else begin
         r.n0 = 32'(rnd_l(ONE_Q30 - s, 1));
         r.n1 = 32'(rnd_l(ONE_Q30 + s, 1));
         r.n2 = '0;
         r.d0 = 32'(-HALF_Q30);
         r.d1 = 32'(HALF_Q30);
         r.d2 = '0;
      end
      r.w = 32'(w);
      return r;
   endfunction

   // gauss points: two for a linear edge, then three for a quadratic edge
   localparam shape_type SHAPE_TAB [5] = '{
      shape_at(1'b0, -S2_Q30, ONE_Q30),
      shape_at(1'b0, S2_Q30, ONE_Q30),
      shape_at(1'b1, -S3_Q30, W5_Q30),
      shape_at(1'b1, 64'sd0, W8_Q30),
      shape_at(1'b1, S3_Q30, W5_Q30)
   };

   // round to nearest, ties away from zero
   function automatic logic signed [PROD_W-1:0] rnd68(input logic signed [PROD_W-1:0] v,
                                                      input int k);
      logic [PROD_W-1:0] m;
      logic [PROD_W-1:0] r;
      m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      r = (m + (PROD_W'(1) << (k - 1))) >> k;
      return v[PROD_W-1] ? $signed(-r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] sat_tan(input logic signed [PROD_W-1:0] v);
      if (v > 68'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -68'sd2147483647) begin
         return 32'sh8000_0001;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat_add48(input logic signed [47:0] s,
                                                    input logic signed [SUM_W-1:0] f);
      logic signed [50:0] t;
      t = 51'(s) + 51'(f);
      if (t > 51'sd140737488355327) begin
         return 48'sh7FFF_FFFF_FFFF;
      end else if (t < -51'sd140737488355328) begin
         return 48'sh8000_0000_0000;
      end
      return t[47:0];
   endfunction

endpackage

/* rtl/core/etla_ram.sv */
// generic single write port, single read port ram with registered read data
module etla_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/etla_isqrt.sv */
// bit-serial integer square root, one result bit per cycle
module etla_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [63:0] rem_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;
   logic        fits;

   assign trial = res_ff + bit_ff;
   assign fits  = rem_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == 64'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

/* rtl/core/edge_traction_load_assembler_core.sv */
// Edge traction load assembler: accumulates a 2D nodal force vector in a per-node ram.
// After reset a clearing pass writes zero to every node before the first item is taken.
// Each gauss point of a linear or quadratic edge runs on the one shared 34x34 multiplier
// (a multiply state, then an accumulate state, for each product) and the bit-serial square
// root, and each node of the edge then costs a read-modify-write on the ram port. A point
// load is a single read-modify-write, and a read item may wait for the result register.
module edge_traction_load_assembler_core #(
   parameter int NODES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [11:0]        req_node_a,
   input  logic [11:0]        req_node_b,
   input  logic [11:0]        req_node_c,
   input  logic signed [31:0] req_x_a,
   input  logic signed [31:0] req_y_a,
   input  logic signed [31:0] req_x_b,
   input  logic signed [31:0] req_y_b,
   input  logic signed [31:0] req_x_c,
   input  logic signed [31:0] req_y_c,
   input  logic signed [31:0] req_traction_x,
   input  logic signed [31:0] req_traction_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_node_force_x,
   output logic signed [47:0] rsp_node_force_y
);

   import etla_pkg::*;

   localparam int AW = $clog2(NODES);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] i_ff, i_in;
   logic [1:0] g_ff, g_in;
   logic [AW-1:0] clr_ff;
   logic          rsp_valid_ff;

   logic [1:0]          cnt_ff;
   logic                quad_ff;
   logic [11:0]         node_ff [3];
   logic signed [31:0]  x_ff [3];
   logic signed [31:0]  y_ff [3];
   logic signed [31:0]  tx_ff;
   logic signed [31:0]  ty_ff;
   logic signed [PROD_W-1:0] sx_ff;
   logic signed [PROD_W-1:0] sy_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [31:0]  dx_ff;
   logic signed [31:0]  dy_ff;
   logic [63:0]         mag_ff;
   logic signed [MUL_W-1:0] ds_ff;
   logic signed [MUL_W-1:0] q_ff;
   logic signed [SUM_W-1:0] fx_ff [3];
   logic signed [SUM_W-1:0] fy_ff [3];
   logic signed [47:0]  out_x_ff;
   logic signed [47:0]  out_y_ff;

   logic                last_i;
   logic                last_g;
   logic [11:0]         cur_node;
   logic                node_ok;
   logic [AW-1:0]       cur_addr;
   logic [2:0]          tab_idx;
   shape_type           sh;
   logic signed [MUL_W-1:0] mul_a;
   logic signed [MUL_W-1:0] mul_b;
   logic signed [31:0]  n_sel;
   logic signed [31:0]  dn_sel;
   logic signed [PROD_W-1:0] rnd30;
   logic signed [PROD_W-1:0] rnd16;
   logic                rsp_free;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [95:0]         ram_wr_data;
   logic                ram_rd_en;
   logic [95:0]         ram_rd_data;
   logic signed [47:0]  upd_x;
   logic signed [47:0]  upd_y;

   logic                sqrt_start;
   logic                sqrt_done;
   logic [31:0]         sqrt_root;

   etla_ram #(
      .WIDTH(96),
      .DEPTH(NODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_addr),
      .rd_data (ram_rd_data)
   );

   etla_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mag_ff + prod_ff[63:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign last_i   = (i_ff == cnt_ff - 2'd1);
   assign last_g   = (g_ff == (quad_ff ? 2'd2 : 2'd1));
   assign cur_node = node_ff[i_ff];
   assign node_ok  = {20'd0, cur_node} < 32'(NODES);
   assign cur_addr = AW'({20'd0, cur_node});
   assign tab_idx  = quad_ff ? 3'({1'b0, g_ff}) + 3'd2 : 3'({1'b0, g_ff});
   assign sh       = SHAPE_TAB[tab_idx];
   assign rnd30    = rnd68(prod_ff, 30);
   assign rnd16    = rnd68(prod_ff, 16);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign upd_x    = sat_add48(ram_rd_data[95:48], fx_ff[i_ff]);
   assign upd_y    = sat_add48(ram_rd_data[47:0], fy_ff[i_ff]);

   always_comb begin
      case (i_ff)
         2'd0: begin
            n_sel  = sh.n0;
            dn_sel = sh.d0;
         end
         2'd1: begin
            n_sel  = sh.n1;
            dn_sel = sh.d1;
         end
         default: begin
            n_sel  = sh.n2;
            dn_sel = sh.d2;
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (phase_ff)
         PH_SX: begin
            mul_a = MUL_W'(dn_sel);
            mul_b = MUL_W'(x_ff[i_ff]);
         end
         PH_SY: begin
            mul_a = MUL_W'(dn_sel);
            mul_b = MUL_W'(y_ff[i_ff]);
         end
         PH_MX: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         PH_MY: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(dy_ff);
         end
         PH_JW: begin
            mul_a = $signed({2'b00, sqrt_root});
            mul_b = MUL_W'(sh.w);
         end
         PH_NQ: begin
            mul_a = MUL_W'(n_sel);
            mul_b = ds_ff;
         end
         PH_TX: begin
            mul_a = MUL_W'(tx_ff);
            mul_b = q_ff;
         end
         default: begin
            mul_a = MUL_W'(ty_ff);
            mul_b = q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_SX;
         i_ff         <= '0;
         g_ff         <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         i_ff     <= i_in;
         g_ff     <= g_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_READ_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      i_in        = i_ff;
      g_in        = g_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr;
      ram_wr_data = {upd_x, upd_y};
      ram_rd_en   = 1'b0;
      sqrt_start  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               i_in     = '0;
               g_in     = '0;
               phase_in = PH_SX;
               case (op_type'(req_operation))
                  OP_LINEAR, OP_QUAD: state_in = ST_MUL;
                  OP_POINT:           state_in = ST_RD;
                  default:            state_in = ST_READ_RD;
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_MUL;
            case (phase_ff)
               PH_SX: begin
                  if (last_i) begin
                     i_in     = '0;
                     phase_in = PH_SY;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end
               PH_SY: begin
                  if (last_i) begin
                     i_in     = '0;
                     phase_in = PH_MX;
                     state_in = ST_TAN;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end
               PH_MX: begin
                  phase_in = PH_MY;
               end
               PH_MY: begin
                  sqrt_start = 1'b1;
                  state_in   = ST_SQRT;
               end
               PH_JW: begin
                  phase_in = PH_NQ;
               end
               PH_NQ: begin
                  phase_in = PH_TX;
               end
               PH_TX: begin
                  phase_in = PH_TY;
               end
               default: begin
                  if (last_i) begin
                     i_in = '0;
                     if (last_g) begin
                        state_in = ST_RD;
                     end else begin
                        g_in     = g_ff + 2'd1;
                        phase_in = PH_SX;
                     end
                  end else begin
                     i_in     = i_ff + 2'd1;
                     phase_in = PH_NQ;
                  end
               end
            endcase
         end
         ST_TAN: begin
            state_in = ST_MUL;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               phase_in = PH_JW;
               state_in = ST_MUL;
            end
         end
         ST_RD: begin
            // nodes beyond the store are skipped
            if (node_ok) begin
               ram_rd_en = 1'b1;
               state_in  = ST_WR;
            end else if (last_i) begin
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         ST_WR: begin
            ram_wr_en = 1'b1;
            if (last_i) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + 2'd1;
               state_in = ST_RD;
            end
         end
         ST_READ_RD: begin
            if (rsp_free) begin
               ram_rd_en = node_ok;
               state_in  = ST_READ_OUT;
            end
         end
         ST_READ_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               node_ff[0] <= req_node_a;
               node_ff[1] <= req_node_b;
               node_ff[2] <= req_node_c;
               x_ff[0]    <= req_x_a;
               y_ff[0]    <= req_y_a;
               x_ff[1]    <= req_x_b;
               y_ff[1]    <= req_y_b;
               x_ff[2]    <= req_x_c;
               y_ff[2]    <= req_y_c;
               tx_ff      <= req_traction_x;
               ty_ff      <= req_traction_y;
               sx_ff      <= '0;
               sy_ff      <= '0;
               quad_ff    <= (op_type'(req_operation) == OP_QUAD);
               // a point load puts its force straight into the first share
               if (op_type'(req_operation) == OP_POINT) begin
                  fx_ff[0] <= SUM_W'(req_traction_x);
                  fy_ff[0] <= SUM_W'(req_traction_y);
               end else begin
                  fx_ff[0] <= '0;
                  fy_ff[0] <= '0;
               end
               for (int k = 1; k < 3; k++) begin
                  fx_ff[k] <= '0;
                  fy_ff[k] <= '0;
               end
               case (op_type'(req_operation))
                  OP_LINEAR: cnt_ff <= 2'd2;
                  OP_QUAD:   cnt_ff <= 2'd3;
                  default:   cnt_ff <= 2'd1;
               endcase
            end
         end
         ST_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         ST_TAN: begin
            dx_ff <= sat_tan(rnd68(sx_ff, 30));
            dy_ff <= sat_tan(rnd68(sy_ff, 30));
         end
         ST_ACC: begin
            case (phase_ff)
               PH_SX: sx_ff <= sx_ff + prod_ff;
               PH_SY: sy_ff <= sy_ff + prod_ff;
               PH_MX: mag_ff <= prod_ff[63:0];
               PH_MY: mag_ff <= mag_ff;
               PH_JW: ds_ff <= rnd30[MUL_W-1:0];
               PH_NQ: q_ff <= rnd30[MUL_W-1:0];
               PH_TX: fx_ff[i_ff] <= fx_ff[i_ff] + $signed(rnd16[SUM_W-1:0]);
               default: begin
                  fy_ff[i_ff] <= fy_ff[i_ff] + $signed(rnd16[SUM_W-1:0]);
                  // next gauss point starts its tangent sums from zero
                  if (last_i) begin
                     sx_ff <= '0;
                     sy_ff <= '0;
                  end
               end
            endcase
         end
         ST_READ_OUT: begin
            out_x_ff <= node_ok ? $signed(ram_rd_data[95:48]) : 48'sd0;
            out_y_ff <= node_ok ? $signed(ram_rd_data[47:0]) : 48'sd0;
         end
         default: begin
            out_x_ff <= out_x_ff;
         end
      endcase
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_force_x = out_x_ff;
   assign rsp_node_force_y = out_y_ff;

endmodule

/* test/tb_edge_traction_load_assembler_core.sv */
// self-checking testbench for the edge traction load assembler core
`timescale 1ns / 1ps

module tb_edge_traction_load_assembler_core;
   import etla_pkg::*;

   typedef struct {
      op_type             op;
      logic [11:0]        na, nb, nc;
      logic signed [31:0] xa, ya, xb, yb, xc, yc, tx, ty;
   } load_item_type;

   localparam int  NUM_NODES  = 4096;
   localparam int  STALL_MAX  = 20000;
   localparam longint F_MAX   = 64'sd140737488355327;
   localparam longint F_MIN   = -64'sd140737488355328;
   localparam longint T_MAX   = 64'sd2147483647;
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint Q30_HALF = 64'sd536870912;

   class force_scoreboard;
      longint fx_mem[NUM_NODES];
      longint fy_mem[NUM_NODES];
      longint want_x[$];
      longint want_y[$];
      int     mismatches;

      function new();
         foreach (fx_mem[i]) begin
            fx_mem[i] = 0;
            fy_mem[i] = 0;
         end
         mismatches = 0;
      endfunction

      function longint round_shift(longint v, int k);
         bit [63:0] m;
         bit [63:0] r;
         m = (v < 0) ? 64'(-v) : 64'(v);
         r = (m + (64'd1 << (k - 1))) >> k;
         return (v < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint clip48(longint v);
         if (v > F_MAX) return F_MAX;
         if (v < F_MIN) return F_MIN;
         return v;
      endfunction

      function longint clip_tan(longint v);
         if (v > T_MAX) return T_MAX;
         if (v < -T_MAX) return -T_MAX;
         return v;
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] v);
         bit [63:0] res;
         bit [63:0] b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void add_node(logic [11:0] node, longint fx, longint fy);
         if (node >= NUM_NODES) return;
         fx_mem[node] = clip48(fx_mem[node] + fx);
         fy_mem[node] = clip48(fy_mem[node] + fy);
      endfunction

      function void integrate_edge(load_item_type it, bit quad);
         longint gs[3], gw[3], n[3], dn[3], x[3], y[3], fx[3], fy[3];
         longint sx, sy, dx, dy, sq, ds, q, s;
         logic [11:0] nd[3];
         bit [63:0] mag2, jac;
         int cnt;
         cnt = quad ? 3 : 2;
         if (quad) begin
            gs = '{-64'sd831716840, 0, 64'sd831716840};
            gw = '{64'sd596523236, 64'sd954437177, 64'sd596523236};
         end else begin
            gs = '{-64'sd619925131, 64'sd619925131, 0};
            gw = '{Q30_ONE, Q30_ONE, 0};
         end
         nd = '{it.na, it.nb, it.nc};
         x = '{it.xa, it.xb, it.xc};
         y = '{it.ya, it.yb, it.yc};
         fx = '{0, 0, 0};
         fy = '{0, 0, 0};
         for (int g = 0; g < cnt; g++) begin
            s = gs[g];
            if (quad) begin
               sq = round_shift(s * s, 30);
               n = '{round_shift(sq - s, 1), round_shift(sq + s, 1), Q30_ONE - sq};
               dn = '{s - Q30_HALF, s + Q30_HALF, -2 * s};
            end else begin
               n = '{round_shift(Q30_ONE - s, 1), round_shift(Q30_ONE + s, 1), 0};
               dn = '{-Q30_HALF, Q30_HALF, 0};
            end
            sx = 0;
            sy = 0;
            for (int i = 0; i < cnt; i++) begin
               sx += dn[i] * x[i];
               sy += dn[i] * y[i];
            end
            dx = clip_tan(round_shift(sx, 30));
            dy = clip_tan(round_shift(sy, 30));
            mag2 = 64'(dx * dx) + 64'(dy * dy);
            jac = int_sqrt(mag2);
            ds = round_shift(longint'(jac) * gw[g], 30);
            for (int i = 0; i < cnt; i++) begin
               q = round_shift(n[i] * ds, 30);
               fx[i] += round_shift(longint'(it.tx) * q, 16);
               fy[i] += round_shift(longint'(it.ty) * q, 16);
            end
         end
         // shares go in a, b, c order so a repeated node saturates step by step
         for (int i = 0; i < cnt; i++) add_node(nd[i], fx[i], fy[i]);
      endfunction

      function void note_item(load_item_type it);
         case (it.op)
            OP_LINEAR: integrate_edge(it, 1'b0);
            OP_QUAD:   integrate_edge(it, 1'b1);
            OP_POINT:  add_node(it.na, longint'(it.tx), longint'(it.ty));
            default: begin
               want_x.push_back(it.na < NUM_NODES ? fx_mem[it.na] : 0);
               want_y.push_back(it.na < NUM_NODES ? fy_mem[it.na] : 0);
            end
         endcase
      endfunction

      function void check_result(logic signed [47:0] fx, logic signed [47:0] fy);
         longint ex, ey;
         if (want_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result fx=%0d fy=%0d", fx, fy);
            return;
         end
         ex = want_x.pop_front();
         ey = want_y.pop_front();
         if (longint'(fx) != ex || longint'(fy) != ey) begin
            mismatches++;
            if (mismatches <= 10)
               $display("force mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                        ex, ey, fx, fy);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic [11:0]        req_node_a, req_node_b, req_node_c;
   logic signed [31:0] req_x_a, req_y_a, req_x_b, req_y_b, req_x_c, req_y_c;
   logic signed [31:0] req_traction_x, req_traction_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [47:0] rsp_node_force_x, rsp_node_force_y;

   force_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  quiet_cycles;
   bit  accepted_any;

   edge_traction_load_assembler_core dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // result side: random stall, check every accepted item
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_node_force_x, rsp_node_force_y);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      accepted_any = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);
      if (reset || accepted_any) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_item(input load_item_type it);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.op;
      req_node_a <= it.na;
      req_node_b <= it.nb;
      req_node_c <= it.nc;
      req_x_a <= it.xa;
      req_y_a <= it.ya;
      req_x_b <= it.xb;
      req_y_b <= it.yb;
      req_x_c <= it.xc;
      req_y_c <= it.yc;
      req_traction_x <= it.tx;
      req_traction_y <= it.ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
   endtask

   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(9) < 7) return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      return $signed($urandom);
   endfunction

   function automatic load_item_type rand_item();
      load_item_type it;
      int pick;
      pick = $urandom_range(99);
      it.op = pick < 35 ? OP_LINEAR : pick < 60 ? OP_QUAD : pick < 75 ? OP_POINT : OP_READ;
      // mostly a small node set so reads land on loaded nodes
      it.na = $urandom_range(9) < 8 ? 12'($urandom_range(31)) : 12'($urandom);
      it.nb = $urandom_range(9) < 8 ? 12'($urandom_range(31)) : 12'($urandom);
      it.nc = $urandom_range(9) < 8 ? 12'($urandom_range(31)) : 12'($urandom);
      it.xa = rand_coord();
      it.ya = rand_coord();
      it.xb = rand_coord();
      it.yb = rand_coord();
      it.xc = rand_coord();
      it.yc = rand_coord();
      it.tx = rand_coord();
      it.ty = rand_coord();
      return it;
   endfunction

   function automatic load_item_type make_item(op_type op, logic [11:0] na, logic [11:0] nb,
                                               logic [11:0] nc, logic signed [31:0] c,
                                               logic signed [31:0] t);
      load_item_type it;
      it.op = op;
      it.na = na;
      it.nb = nb;
      it.nc = nc;
      it.xa = -c;
      it.ya = c >>> 1;
      it.xb = c;
      it.yb = -(c >>> 2);
      it.xc = c >>> 3;
      it.yc = c >>> 4;
      it.tx = t;
      it.ty = -t;
      return it;
   endfunction

   initial begin
      load_item_type it;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_READ;
      {req_node_a, req_node_b, req_node_c} = '0;
      {req_x_a, req_y_a, req_x_b, req_y_b, req_x_c, req_y_c} = '0;
      {req_traction_x, req_traction_y} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: zero read, extremes, every operation, repeats and saturation
      send_item(make_item(OP_READ, 12'd0, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_READ, 12'hFFF, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_POINT, 12'hFFF, 12'd0, 12'd0, 0, 32'sh7FFF_FFFF));
      send_item(make_item(OP_POINT, 12'd1, 12'd0, 12'd0, 0, 32'sh8000_0000));
      send_item(make_item(OP_READ, 12'hFFF, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_READ, 12'd1, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_LINEAR, 12'd2, 12'd3, 12'd4, 32'sh0002_0000, 32'sh0001_0000));
      send_item(make_item(OP_QUAD, 12'd2, 12'd3, 12'd4, 32'sh0003_8000, 32'sh0000_4000));
      send_item(make_item(OP_READ, 12'd2, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_READ, 12'd4, 12'd0, 12'd0, 0, 0));
      // huge tangent: coordinates at both ends of the range
      it = make_item(OP_LINEAR, 12'd6, 12'd7, 12'd0, 0, 32'sh0001_0000);
      it.xa = 32'sh8000_0000;
      it.xb = 32'sh7FFF_FFFF;
      it.ya = 32'sh7FFF_FFFF;
      it.yb = 32'sh8000_0000;
      send_item(it);
      send_item(make_item(OP_READ, 12'd6, 12'd0, 12'd0, 0, 0));
      // repeated node in one edge, large values, until the store saturates
      for (int i = 0; i < 4; i++)
         send_item(make_item(OP_QUAD, 12'd5, 12'd5, 12'd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_item(make_item(OP_READ, 12'd5, 12'd0, 12'd0, 0, 0));
      for (int i = 0; i < 4; i++)
         send_item(make_item(OP_QUAD, 12'd8, 12'd8, 12'd9, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_item(make_item(OP_READ, 12'd8, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_READ, 12'd9, 12'd0, 12'd0, 0, 0));
      send_item(make_item(OP_READ, 12'd5, 12'd0, 12'd0, 0, 0));

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            3: begin send_idle_pct = 28; recv_stall_pct = 28; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (ph == 3) begin
            // hold off until every read has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.want_x.size() != 0) @(posedge clock);
         end
         for (int i = 0; i < 250; i++) send_item(rand_item());
      end
      req_valid <= 1'b0;

      while (sb.want_x.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
